// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AST_CLKD(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also checks through reset.
`define AST_CLKD_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== rtl/core/s2a_pkg.sv =====
package s2a_pkg;

  localparam int TABLE_ENTRIES = 90;
  localparam int MAP_ENTRIES   = 90;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_TAB  = 2'd2,
    KIND_LED  = 2'd3
  } kind_t;

  localparam logic [6:0] CODE_LSHIFT = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT = 7'h36;
  localparam logic [6:0] CODE_CTRL   = 7'h1D;
  localparam logic [6:0] CODE_ALT    = 7'h38;
  localparam logic [6:0] CODE_CAPS   = 7'h3A;
  localparam logic [6:0] CODE_NUM    = 7'h45;
  localparam logic [6:0] CODE_SCROLL = 7'h46;

  localparam logic [6:0] CHAR_TAB    = 7'd9;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  typedef struct packed {
    logic       data_ready;
    logic [7:0] scancode;
  } in_beat_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] char_code;
    logic [2:0] led_bits;
    logic       ctrl_held;
    logic       alt_held;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic num;
    logic scroll;
  } flags_t;

  // What the front stage hands to the resolve stage with each beat.
  typedef struct packed {
    logic       lookup;
    logic       led_evt;
    logic [2:0] leds;
    logic       caps;
    logic       shift;
    logic       ctrl;
    logic       alt;
  } front_info_t;

  localparam logic [6:0] PLAIN_MAP [MAP_ENTRIES] = '{
    7'd0,   7'd0,   7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
    7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
    7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
    7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd55,
    7'd56,  7'd57,  7'd45,  7'd52,  7'd53,  7'd54,  7'd43,  7'd49,
    7'd50,  7'd51,  7'd48,  7'd46,  7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0
  };

  localparam logic [6:0] SHIFT_MAP [MAP_ENTRIES] = '{
    7'd0,   7'd0,   7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
    7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
    7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
    7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
    7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
    7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
    7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd55,
    7'd56,  7'd57,  7'd45,  7'd52,  7'd53,  7'd54,  7'd43,  7'd49,
    7'd50,  7'd51,  7'd48,  7'd46,  7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0
  };

  // Address is {shift, key code}; codes past the table read as zero.
  function automatic logic [6:0] keymap_entry(input logic [7:0] addr);
    logic [6:0] code;
    logic [6:0] val;
    code = addr[6:0];
    val  = 7'd0;
    if ((code < 7'(MAP_ENTRIES)) && ({1'b0, code} < 8'(TABLE_ENTRIES))) begin
      val = addr[7] ? SHIFT_MAP[code] : PLAIN_MAP[code];
    end
    return val;
  endfunction

endpackage

// ===== rtl/core/s2a_keymap_rom.sv =====
module s2a_keymap_rom (
  input  logic       clk,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [6:0] rd_data
);
  import s2a_pkg::*;

  logic [6:0] rd_data_r;

  // Synchronous ROM: the entry is registered, shows in the cycle after the address
  // and holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= keymap_entry(rd_addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/s2a_flag_unit.sv =====
module s2a_flag_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  s2a_pkg::in_beat_t     beat,
  output s2a_pkg::front_info_t  info,
  output logic [7:0]            rom_addr
);
  import s2a_pkg::*;

  flags_t     flags_r;
  flags_t     flags_nxt;
  logic       released;
  logic [6:0] code;
  logic       lookup;
  logic       led_evt;

  assign released = beat.scancode[7];
  assign code     = beat.scancode[6:0];

  always_comb begin
    flags_nxt = flags_r;
    lookup    = 1'b0;
    led_evt   = 1'b0;
    if (beat.data_ready) begin
      case (code)
        CODE_LSHIFT, CODE_RSHIFT: begin
          flags_nxt.shift = !released;
        end
        CODE_CTRL: begin
          flags_nxt.ctrl = !released;
        end
        CODE_ALT: begin
          flags_nxt.alt = !released;
        end
        CODE_CAPS, CODE_NUM, CODE_SCROLL: begin
          // Lock keys toggle on press only; a release does nothing.
          if (!released) begin
            led_evt = 1'b1;
            if (code == CODE_CAPS) begin
              flags_nxt.caps = !flags_r.caps;
            end else if (code == CODE_NUM) begin
              flags_nxt.num = !flags_r.num;
            end else begin
              flags_nxt.scroll = !flags_r.scroll;
            end
          end
        end
        default: begin
          lookup = !released;
        end
      endcase
    end
  end

  always_comb begin
    info.lookup  = lookup;
    info.led_evt = led_evt;
    info.leds    = {flags_nxt.caps, flags_nxt.num, flags_nxt.scroll};
    info.caps    = flags_r.caps;
    info.shift   = flags_r.shift;
    info.ctrl    = flags_nxt.ctrl;
    info.alt     = flags_nxt.alt;
  end

  assign rom_addr = {flags_r.shift, code};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (accept) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

// ===== rtl/core/scancode_to_ascii_decoder_top.sv =====
// Set-1 keyboard scancode to ASCII decoder.
//
// Input channel (in_valid / in_stall / in_beat): one raw scancode byte per
// beat with its data-ready bit. Output channel (out_valid / out_stall /
// out_beat): exactly one result beat for every input beat, in order.
//
// A beat accepted into the lookup stage moves on to the output register,
// which drives out_valid. Throughput: one beat per cycle while the output
// is not stalled, set by the single read port of the keymap ROM, which is
// addressed in the accept cycle and read in the next.
//
// Modifier and lock flags update at the accept edge, so back-to-back beats
// always see the flags left by the beat before.
// While out_stall holds a result, one more beat is taken into the lookup
// stage; after that in_stall rises until the output drains.
// Reset (rst_n low, synchronous) clears all flags and empties both stages.
module scancode_to_ascii_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  s2a_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output s2a_pkg::out_beat_t  out_beat
);
  import s2a_pkg::*;

  logic        in_accept;
  logic        adv;
  front_info_t info;
  logic [7:0]  rom_addr;
  logic [6:0]  rom_data;

  logic        s1_valid_r;
  front_info_t s1_info_r;
  logic        out_valid_r;
  out_beat_t   out_beat_r;

  logic [6:0]  ch;
  out_beat_t   res;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  s2a_flag_unit u_flags (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .beat     (in_beat),
    .info     (info),
    .rom_addr (rom_addr)
  );

  s2a_keymap_rom u_rom (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Caps lock uppercases letters; with shift held it flips them back.
  always_comb begin
    ch = rom_data;
    if (s1_info_r.caps && (rom_data inside {[7'd97:7'd122]})) begin
      ch = rom_data - CASE_OFFSET;
    end else if (s1_info_r.caps && s1_info_r.shift &&
                 (rom_data inside {[7'd65:7'd90]})) begin
      ch = rom_data + CASE_OFFSET;
    end
  end

  always_comb begin
    res.kind      = KIND_NONE;
    res.char_code = 7'd0;
    res.led_bits  = 3'd0;
    res.ctrl_held = s1_info_r.ctrl;
    res.alt_held  = s1_info_r.alt;
    if (s1_info_r.led_evt) begin
      res.kind     = KIND_LED;
      res.led_bits = s1_info_r.leds;
    end else if (s1_info_r.lookup) begin
      if (ch == CHAR_TAB) begin
        res.kind = KIND_TAB;
      end else if (ch != 7'd0) begin
        res.kind      = KIND_CHAR;
        res.char_code = ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_info_r <= info;
    end
    if (adv && s1_valid_r) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ===== rtl/core/s2a_checker.sv =====
`include "assert_macros.svh"

module s2a_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input s2a_pkg::out_beat_t  out_beat
);
  import s2a_pkg::*;

  // A held result beat stays put until it is taken.
  `AST_CLKD(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_beat))

  // Only a character beat carries a character code.
  `AST_CLKD(a_char_only, out_valid && (out_beat.kind != KIND_CHAR) |-> out_beat.char_code == 7'd0)

  // LED bits appear only on an LED update.
  `AST_CLKD(a_led_only, out_valid && (out_beat.kind != KIND_LED) |-> out_beat.led_bits == 3'd0)

  // Reset empties the pipeline, and the input is open right after it.
  `AST_CLKD_RST(a_reset_empty, !rst_n |=> !out_valid && !in_stall)

endmodule

bind scancode_to_ascii_decoder_top s2a_checker u_s2a_checker (.*);
